>>> hw/rtl/wase_pkg.sv
`timescale 1ns / 1ps

package wase_pkg;

    localparam int ANGLE_W = 13;
    localparam int TIME_W  = 32;
    localparam int POS_W   = 32;
    localparam int SPEED_W = 32;

    // Unwrap arithmetic: wide enough for an angle difference and a full turn
    localparam int STEP_W = 18;
    localparam logic signed [STEP_W-1:0] TURN_MRAD      = 18'sd6283;
    localparam logic signed [STEP_W-1:0] HALF_TURN_MRAD = 18'sd3142;
    localparam logic signed [STEP_W-1:0] NEG_HALF_TURN  = -18'sd3142;

    // mrad/ms to mrad/s
    localparam int SCALE_W = 10;
    localparam logic [SCALE_W-1:0] MS_PER_S = 10'd1000;

    localparam int NUM_W = POS_W + SCALE_W;
    localparam int DEN_W = TIME_W;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    localparam logic [SPEED_W-1:0] SPEED_MAX = 32'h7FFF_FFFF;
    localparam logic [SPEED_W-1:0] SPEED_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [TIME_W-1:0] stamp;
    } ring_entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UNWRAP,
        S_DIFF,
        S_MAG,
        S_MUL,
        S_DIV,
        S_DONE
    } state_t;

endpackage

>>> hw/rtl/wase_sample_if.sv
`timescale 1ns / 1ps

interface wase_sample_if;
    import wase_pkg::*;

    logic               valid;
    logic               ready;
    logic [ANGLE_W-1:0] angle_mrad;
    logic [TIME_W-1:0]  time_ms;

    modport source (output valid, output angle_mrad, output time_ms, input ready);
    modport sink   (input valid, input angle_mrad, input time_ms, output ready);
endinterface

>>> hw/rtl/wase_speed_if.sv
`timescale 1ns / 1ps

interface wase_speed_if;
    import wase_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] speed_mrad_s;

    modport source (output valid, output speed_mrad_s, input ready);
    modport sink   (input valid, input speed_mrad_s, output ready);
endinterface

>>> hw/rtl/wase_ring.sv
`timescale 1ns / 1ps

module wase_ring #(
    parameter int DEPTH = 20,
    parameter int AW    = 5
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  wase_pkg::ring_entry_t wdata,
    input  logic                  re,
    input  logic [AW-1:0]         raddr,
    output wase_pkg::ring_entry_t rdata
);
    import wase_pkg::*;

    ring_entry_t mem [DEPTH];
    ring_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/wase_div.sv
`timescale 1ns / 1ps

module wase_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [wase_pkg::NUM_W-1:0]  dividend,
    input  logic [wase_pkg::DEN_W-1:0]  divisor,
    output logic                        done,
    output logic [wase_pkg::NUM_W-1:0]  quotient
);
    import wase_pkg::*;

    logic                 active_reg, active_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [NUM_W-1:0]     quo_reg, quo_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic [DEN_W:0]       trial;
    logic [DEN_W:0]       diff;
    logic                 fits;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        den_next    = den_reg;
        if (start)
        begin
            active_next = 1'b1;
            cnt_next    = DIV_CNT_W'(NUM_W - 1);
            rem_next    = '0;
            quo_next    = dividend;
            den_next    = divisor;
        end
        else if (active_reg)
        begin
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> hw/rtl/windowed_angle_speed_estimator_unit.sv
`timescale 1ns / 1ps
// Sequence: the first sample goes from accept through the unwrap step straight to the
// output step and reports zero; every later sample passes 4 sequencer steps (unwrap,
// difference, magnitude, multiply), the radix-2 divider and 1 output step; the divider
// is skipped when elapsed time is zero. A new sample is taken only from idle, and a
// result word the sink has not taken holds the sequencer in its output step.
// Reset: rst_n is asynchronous, active low; clears the sequencer, fill count,
// ring slot and position. Ring contents are not cleared and are never read unwritten.
module windowed_angle_speed_estimator_unit #(
    parameter int WINDOW = 20
) (
    input logic          clk,
    input logic          rst_n,
    wase_sample_if.sink  sample,
    wase_speed_if.source speed
);
    import wase_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);

    state_t              state_reg, state_next;
    logic                started_reg, started_next;
    logic [ANGLE_W-1:0]  last_angle_reg, last_angle_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic                out_valid_reg, out_valid_next;

    logic [ANGLE_W-1:0]  angle_reg, angle_next;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic [POS_W-1:0]    dpos_reg, dpos_next;
    logic [TIME_W-1:0]   elapsed_reg, elapsed_next;
    logic [POS_W-1:0]    mag_reg, mag_next;
    logic                neg_reg, neg_next;
    logic                zero_reg, zero_next;
    logic [SPEED_W-1:0]  out_speed_reg, out_speed_next;

    logic signed [STEP_W-1:0] cur_s, prev_s, diff_s, step_s;
    logic [POS_W-1:0]    pos_sum;
    logic                filling;
    logic [SLOT_W-1:0]   slot_inc;
    logic [SLOT_W-1:0]   ref_slot;

    logic                ring_we, ring_re;
    logic [SLOT_W-1:0]   ring_waddr, ring_raddr;
    ring_entry_t         ring_wdata, ring_rdata;

    logic                div_start, div_done;
    logic [NUM_W-1:0]    div_dividend, quotient;
    logic                q_over;
    logic [SPEED_W-1:0]  speed_sat;
    logic                load_out;

    // unwrap across the zero crossing
    always_comb
    begin
        cur_s  = $signed({{(STEP_W - ANGLE_W){1'b0}}, angle_reg});
        prev_s = $signed({{(STEP_W - ANGLE_W){1'b0}}, last_angle_reg});
        diff_s = cur_s - prev_s;
        if (diff_s > HALF_TURN_MRAD)
        begin
            step_s = diff_s - TURN_MRAD;
        end
        else if (diff_s < NEG_HALF_TURN)
        begin
            step_s = diff_s + TURN_MRAD;
        end
        else
        begin
            step_s = diff_s;
        end
    end

    assign pos_sum  = pos_reg + {{(POS_W - STEP_W){step_s[STEP_W-1]}}, step_s};
    assign filling  = (fill_reg < CNT_W'(WINDOW));
    assign slot_inc = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
    assign ref_slot = filling ? '0 : slot_inc;

    assign div_dividend = NUM_W'(mag_reg) * NUM_W'(MS_PER_S);
    assign div_start    = (state_reg == S_MUL) && !zero_reg;

    // saturate the quotient into the signed result range
    always_comb
    begin
        q_over = (quotient[NUM_W-1:SPEED_W-1] != '0);
        if (zero_reg)
        begin
            speed_sat = '0;
        end
        else if (neg_reg)
        begin
            speed_sat = q_over ? SPEED_MIN : ('0 - quotient[SPEED_W-1:0]);
        end
        else
        begin
            speed_sat = q_over ? SPEED_MAX : quotient[SPEED_W-1:0];
        end
    end

    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || speed.ready);

    always_comb
    begin
        state_next      = state_reg;
        started_next    = started_reg;
        last_angle_next = last_angle_reg;
        pos_next        = pos_reg;
        slot_next       = slot_reg;
        fill_next       = fill_reg;
        angle_next      = angle_reg;
        time_next       = time_reg;
        dpos_next       = dpos_reg;
        elapsed_next    = elapsed_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        zero_next       = zero_reg;
        out_speed_next  = out_speed_reg;
        out_valid_next  = out_valid_reg && !speed.ready;
        ring_we         = 1'b0;
        ring_re         = 1'b0;
        ring_waddr      = slot_reg;
        ring_raddr      = ref_slot;
        ring_wdata      = '{pos: pos_sum, stamp: time_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (sample.valid)
                begin
                    angle_next = sample.angle_mrad;
                    time_next  = sample.time_ms;
                    state_next = S_UNWRAP;
                end
            end
            S_UNWRAP:
            begin
                last_angle_next = angle_reg;
                ring_we         = 1'b1;
                if (!started_reg)
                begin
                    // first sample: seed slot 0, report zero
                    started_next = 1'b1;
                    pos_next     = '0;
                    ring_waddr   = '0;
                    ring_wdata   = '{pos: '0, stamp: time_reg};
                    slot_next    = SLOT_W'(1);
                    fill_next    = CNT_W'(1);
                    zero_next    = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    pos_next   = pos_sum;
                    ring_re    = 1'b1;
                    slot_next  = slot_inc;
                    if (filling)
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                dpos_next    = pos_reg - ring_rdata.pos;
                elapsed_next = time_reg - ring_rdata.stamp;
                state_next   = S_MAG;
            end
            S_MAG:
            begin
                neg_next   = dpos_reg[POS_W-1];
                mag_next   = dpos_reg[POS_W-1] ? (~dpos_reg + 1'b1) : dpos_reg;
                zero_next  = (elapsed_reg == '0);
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = zero_reg ? S_DONE : S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (load_out)
                begin
                    out_speed_next = speed_sat;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            started_reg    <= 1'b0;
            last_angle_reg <= '0;
            pos_reg        <= '0;
            slot_reg       <= '0;
            fill_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            started_reg    <= started_next;
            last_angle_reg <= last_angle_next;
            pos_reg        <= pos_next;
            slot_reg       <= slot_next;
            fill_reg       <= fill_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg     <= angle_next;
        time_reg      <= time_next;
        dpos_reg      <= dpos_next;
        elapsed_reg   <= elapsed_next;
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        zero_reg      <= zero_next;
        out_speed_reg <= out_speed_next;
    end

    wase_ring #(
        .DEPTH (WINDOW),
        .AW    (SLOT_W)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .re    (ring_re),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    wase_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (elapsed_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign sample.ready       = (state_reg == S_IDLE);
    assign speed.valid        = out_valid_reg;
    assign speed.speed_mrad_s = $signed(out_speed_reg);

`ifndef SYNTH
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(slot_reg) < WINDOW) && (fill_reg <= CNT_W'(WINDOW)))
        else $error("ring slot or fill count out of range");

    a_fill_tracks_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (started_reg && filling) |-> (CNT_W'(slot_reg) == fill_reg))
        else $error("ring slot does not follow fill count while filling");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> (state_reg == S_UNWRAP))
        else $error("accepted word did not start the sequencer");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide step");
`endif

endmodule
